### src/tiba_pkg.sv
// Shared types, widths and constants of the temporal IIR band-pass amplifier.
package tiba_pkg;

  localparam int unsigned MAX_PIXELS_DEF  = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 8;

  localparam logic [COEFF_W-1:0] HIGH_CUTOFF_RST = 16'd26214;
  localparam logic [COEFF_W-1:0] LOW_CUTOFF_RST  = 16'd3277;
  localparam logic [COEFF_W-1:0] GAIN_RST        = 16'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_CUTOFF = 2'd0,
    REG_LOW_CUTOFF  = 2'd1,
    REG_GAIN        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COEFF_W-1:0] high_cutoff;
    logic [COEFF_W-1:0] low_cutoff;
    logic [COEFF_W-1:0] gain;
  } coeff_t;

  typedef struct packed {
    logic signed [BAND_W-1:0] red;
    logic signed [BAND_W-1:0] green;
    logic signed [BAND_W-1:0] blue;
  } band_t;

endpackage

### src/tiba_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
module tiba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/tiba_idx.sv
// Two-stage reduction of the raster index to a frame store address.
module tiba_idx #(
  parameter int unsigned MAX_PIXELS = tiba_pkg::MAX_PIXELS_DEF,
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  logic                         clk_i,
  input  logic [tiba_pkg::INDEX_W-1:0] pixel_index_i,
  output logic [AW-1:0]                addr_o
);

  localparam int unsigned IW = tiba_pkg::INDEX_W;
  localparam bit Direct = (MAX_PIXELS >= (1 << IW)) ||
                          ((MAX_PIXELS & (MAX_PIXELS - 1)) == 0);

  if (Direct) begin : g_direct
    // Power-of-two stores wrap by masking; ones of 2^IW or more need no wrap.
    localparam logic [AW-1:0] Mask = (MAX_PIXELS >= (1 << IW)) ? '1 : AW'(MAX_PIXELS - 1);
    logic [AW-1:0] stage_a_q;
    logic [AW-1:0] stage_b_q;

    always_ff @(posedge clk_i) begin
      stage_a_q <= AW'(pixel_index_i) & Mask;
      stage_b_q <= stage_a_q;
    end

    assign addr_o = stage_b_q;
  end else begin : g_recip
    // The quotient estimate from the reciprocal is at most one low, so the
    // remainder needs one compare and subtract.
    localparam logic [31:0]    Recip   = 32'((64'd1 << 32) / MAX_PIXELS);
    localparam logic [IW-1:0]  Modulus = IW'(MAX_PIXELS);

    logic [IW+31:0] prod;
    logic [IW-1:0]  val_q;
    logic [IW-1:0]  quot_q;
    logic [IW:0]    rem;
    logic [IW-1:0]  rem_fix;
    logic [AW-1:0]  addr_q;

    assign prod = {32'd0, pixel_index_i} * {{IW{1'b0}}, Recip};

    always_ff @(posedge clk_i) begin
      val_q  <= pixel_index_i;
      quot_q <= prod[IW+31:32];
    end

    assign rem     = {1'b0, val_q} - (IW+1)'(quot_q * Modulus);
    assign rem_fix = (rem >= {1'b0, Modulus}) ? IW'(rem - {1'b0, Modulus}) : IW'(rem);

    always_ff @(posedge clk_i) begin
      addr_q <= AW'(rem_fix);
    end

    assign addr_o = addr_q;
  end

endmodule

### src/tiba_lane.sv
// One color lane: fast and slow low-pass update, then amplified difference.
module tiba_lane #(
  parameter int unsigned SAMPLE_BITS = tiba_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned SW = SAMPLE_BITS + tiba_pkg::FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  input  logic [SW-1:0]                      fast_i,
  input  logic [SW-1:0]                      slow_i,
  input  tiba_pkg::coeff_t                   coeff_i,
  output logic [SW-1:0]                      fast_o,
  output logic [SW-1:0]                      slow_o,
  output logic signed [tiba_pkg::BAND_W-1:0] band_o
);

  localparam int unsigned CW = tiba_pkg::COEFF_W;
  localparam int unsigned BW = tiba_pkg::BAND_W;
  localparam int unsigned PW = SW + CW + 2;

  localparam logic signed [PW-1:0] Half   = PW'(1 << (CW - 1));
  localparam logic signed [PW-1:0] SatMax = PW'((1 << (BW - 1)) - 1);
  localparam logic signed [PW-1:0] SatMin = -PW'(1 << (BW - 1));

  // s' = s + round(w * (x - s) / 2^16), the same as the convex blend.
  function automatic logic [SW-1:0] blend(logic [SW-1:0] s, logic [SW-1:0] x,
                                          logic [CW-1:0] w);
    logic signed [SW:0]   diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] step;
    diff = $signed({1'b0, x}) - $signed({1'b0, s});
    prod = diff * $signed({1'b0, w});
    step = (prod + Half) >>> CW;
    return s + step[SW-1:0];
  endfunction

  logic [SW-1:0]        x;
  logic [SW-1:0]        fast_q;
  logic [SW-1:0]        slow_q;
  logic signed [SW:0]   diff;
  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] amp;

  assign x = {sample_i, {tiba_pkg::FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    fast_q <= blend(fast_i, x, coeff_i.high_cutoff);
    slow_q <= blend(slow_i, x, coeff_i.low_cutoff);
  end

  assign fast_o = fast_q;
  assign slow_o = slow_q;

  assign diff   = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
  assign prod_d = diff * $signed({1'b0, coeff_i.gain});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign amp = (prod_q + Half) >>> CW;

  always_comb begin
    if (amp > SatMax) begin
      band_o = SatMax[BW-1:0];
    end else if (amp < SatMin) begin
      band_o = SatMin[BW-1:0];
    end else begin
      band_o = amp[BW-1:0];
    end
  end

endmodule

### src/tiba_fifo.sv
// Result queue that holds the merged lane results until the output takes them.
module tiba_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tiba_pkg::band_t data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tiba_pkg::band_t data_o
);

  localparam int unsigned Depth = tiba_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tiba_pkg::band_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign data_o      = mem_q[rd_ptr_q];

  // The input credit limit must keep a push from landing on a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CntW'(Depth)))
    else $error("result pushed into a full queue");

endmodule

### src/temporal_iir_bandpass_amplifier_unit.sv
// Top level of the temporal IIR band-pass amplifier with per-pixel frame stores.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   pixel_index_i, red/green/blue_sample_i
//   out       output     out_valid_o / out_ready_i red/green/blue_band_o
//   cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One pixel is taken every clock cycle while in_ready_o is high. A result
// passes the index, lane update, amplify and round/saturate stages and is
// queued before it is offered; the frame store read-modify-write loop is
// closed by forwarding the two most recent updates past the RAMs.
// After reset a clearing pass writes zero to every entry; in_ready_o stays
// low during that pass.
// Up to eight results are held when the output side stalls; once eight
// transfers are outstanding, in_ready_o drops until a result is taken.
module temporal_iir_bandpass_amplifier_unit #(
  parameter int unsigned MAX_PIXELS  = tiba_pkg::MAX_PIXELS_DEF,
  parameter int unsigned SAMPLE_BITS = tiba_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tiba_pkg::INDEX_W-1:0]         pixel_index_i,
  input  logic [tiba_pkg::SAMPLE_W-1:0]        red_sample_i,
  input  logic [tiba_pkg::SAMPLE_W-1:0]        green_sample_i,
  input  logic [tiba_pkg::SAMPLE_W-1:0]        blue_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tiba_pkg::BAND_W-1:0]   red_band_o,
  output logic signed [tiba_pkg::BAND_W-1:0]   green_band_o,
  output logic signed [tiba_pkg::BAND_W-1:0]   blue_band_o,
  input  logic                                 cfg_we_i,
  input  logic [tiba_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tiba_pkg::COEFF_W-1:0]         cfg_wdata_i
);

  localparam int unsigned AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SW    = SAMPLE_BITS + tiba_pkg::FRAC_BITS;
  localparam int unsigned NCH   = tiba_pkg::CHANNELS;
  localparam int unsigned EW    = NCH * SW;
  localparam int unsigned Depth = tiba_pkg::FIFO_DEPTH;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // Configuration registers. Write only while the block is idle; this is not enforced.
  tiba_pkg::coeff_t coeff_q, coeff_d;

  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tiba_pkg::REG_HIGH_CUTOFF: coeff_d.high_cutoff = cfg_wdata_i;
        tiba_pkg::REG_LOW_CUTOFF:  coeff_d.low_cutoff  = cfg_wdata_i;
        tiba_pkg::REG_GAIN:        coeff_d.gain        = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q.high_cutoff <= tiba_pkg::HIGH_CUTOFF_RST;
      coeff_q.low_cutoff  <= tiba_pkg::LOW_CUTOFF_RST;
      coeff_q.gain        <= tiba_pkg::GAIN_RST;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  // Clearing pass over both frame stores after reset.
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(MAX_PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Credits count transfers accepted whose results have not yet been taken.
  // Every item in the pipeline or the result queue holds one credit, so the
  // queue can never overflow.
  logic [CntW-1:0] credit_q, credit_d;
  logic            in_xfer;
  logic            out_xfer;

  assign in_ready_o = !clr_busy_q && (credit_q < CntW'(Depth));
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_o && out_ready_i;
  assign credit_d   = credit_q + CntW'(in_xfer) - CntW'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // Pipeline valid bits:
  //   stage a: index reduction, stage b: store address ready and RAM read,
  //   s1: lane update, s2: store write-back and amplify, s3: round/saturate.
  logic va_q, vb_q, s1_valid_q, s2_valid_q, s3_valid_q, wb_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q       <= 1'b0;
      vb_q       <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
    end else begin
      va_q       <= in_xfer;
      vb_q       <= va_q;
      s1_valid_q <= vb_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      wb_valid_q <= s2_valid_q;
    end
  end

  // Sample bits above SAMPLE_BITS are dropped as the transfer is taken.
  logic [SAMPLE_BITS-1:0] smp_in   [NCH];
  logic [SAMPLE_BITS-1:0] smp_a_q  [NCH];
  logic [SAMPLE_BITS-1:0] smp_b_q  [NCH];
  logic [SAMPLE_BITS-1:0] smp_s1_q [NCH];

  assign smp_in[0] = SAMPLE_BITS'(red_sample_i);
  assign smp_in[1] = SAMPLE_BITS'(green_sample_i);
  assign smp_in[2] = SAMPLE_BITS'(blue_sample_i);

  always_ff @(posedge clk_i) begin
    smp_a_q  <= smp_in;
    smp_b_q  <= smp_a_q;
    smp_s1_q <= smp_b_q;
  end

  // Raster index to store address.
  logic [AW-1:0] rd_addr;

  tiba_idx #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_idx (
    .clk_i        (clk_i),
    .pixel_index_i(pixel_index_i),
    .addr_o       (rd_addr)
  );

  logic [AW-1:0] s1_addr_q;
  logic [AW-1:0] s2_addr_q;
  logic [AW-1:0] wb_addr_q;

  always_ff @(posedge clk_i) begin
    s1_addr_q <= rd_addr;
    s2_addr_q <= s1_addr_q;
    wb_addr_q <= s2_addr_q;
  end

  // Frame stores. Each entry holds the state of all three channels.
  wire  [EW-1:0] fast_wr;
  wire  [EW-1:0] slow_wr;
  logic [EW-1:0] fast_rd, slow_rd;
  logic [EW-1:0] fast_cur, slow_cur;
  logic [EW-1:0] wb_fast_q, wb_slow_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_fast_wdata, ram_slow_wdata;

  assign ram_we         = clr_busy_q || s2_valid_q;
  assign ram_waddr      = clr_busy_q ? clr_addr_q : s2_addr_q;
  assign ram_fast_wdata = clr_busy_q ? '0 : fast_wr;
  assign ram_slow_wdata = clr_busy_q ? '0 : slow_wr;

  tiba_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PIXELS)
  ) u_fast_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_fast_wdata),
    .raddr_i(rd_addr),
    .rdata_o(fast_rd)
  );

  tiba_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PIXELS)
  ) u_slow_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_slow_wdata),
    .raddr_i(rd_addr),
    .rdata_o(slow_rd)
  );

  // Remember the last write so a read taken in the same cycle as that write
  // (which returns the old entry) can still be corrected.
  always_ff @(posedge clk_i) begin
    wb_fast_q <= fast_wr;
    wb_slow_q <= slow_wr;
  end

  // Forwarding: the pixel one behind reads before the write lands and takes
  // the s2 value; the pixel two behind reads during the write and takes the
  // write-back copy. The newer update wins.
  logic hit_s2, hit_wb;

  assign hit_s2 = s2_valid_q && (s2_addr_q == s1_addr_q);
  assign hit_wb = wb_valid_q && (wb_addr_q == s1_addr_q);

  always_comb begin
    if (hit_s2) begin
      fast_cur = fast_wr;
      slow_cur = slow_wr;
    end else if (hit_wb) begin
      fast_cur = wb_fast_q;
      slow_cur = wb_slow_q;
    end else begin
      fast_cur = fast_rd;
      slow_cur = slow_rd;
    end
  end

  // One lane per color channel.
  logic signed [tiba_pkg::BAND_W-1:0] lane_band [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    tiba_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .sample_i(smp_s1_q[c]),
      .fast_i  (fast_cur[c*SW +: SW]),
      .slow_i  (slow_cur[c*SW +: SW]),
      .coeff_i (coeff_q),
      .fast_o  (fast_wr[c*SW +: SW]),
      .slow_o  (slow_wr[c*SW +: SW]),
      .band_o  (lane_band[c])
    );
  end

  // Merge the lane results into one queued result.
  tiba_pkg::band_t band_in, band_out;

  assign band_in.red   = lane_band[0];
  assign band_in.green = lane_band[1];
  assign band_in.blue  = lane_band[2];

  tiba_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s3_valid_q),
    .data_i     (band_in),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_o     (band_out)
  );

  assign red_band_o   = band_out.red;
  assign green_band_o = band_out.green;
  assign blue_band_o  = band_out.blue;

  // Outstanding credits never exceed the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CntW'(Depth))
    else $error("credit count above queue depth");

  // No pixel may be in flight while the clearing pass owns the store write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(va_q || vb_q || s1_valid_q || s2_valid_q || s3_valid_q))
    else $error("pixel in flight during store clearing");

  // Every pixel in the pipeline holds a credit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({va_q, vb_q, s1_valid_q, s2_valid_q, s3_valid_q}) <= credit_q)
    else $error("pipeline holds more pixels than credits");

  // A result on offer always stands for an accepted transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (credit_q != '0))
    else $error("result offered without an outstanding transfer");

endmodule
